@@ rtl/blecrcw_pkg.sv @@
// Shared types, constants and helper functions for the BLE CRC-24 / whitening
// transmit block. No dependencies.

package blecrcw_pkg;

  // Configuration register indexes
  localparam logic CfgChannel = 1'b0;
  localparam logic CfgCrcSeed = 1'b1;

  localparam logic [5:0]  ChannelReset = 6'd37;
  localparam logic [23:0] CrcSeedReset = 24'h555555;
  localparam logic [5:0]  IdxMax       = 6'd63;

  // Advertising channels that carry a whitening sequence
  localparam logic [5:0] ChAdv37 = 6'd37;
  localparam logic [5:0] ChAdv38 = 6'd38;
  localparam logic [5:0] ChAdv39 = 6'd39;

  // One whitening key per packet position (6-bit position space)
  typedef logic [63:0][7:0] wtab_t;

  function automatic logic [7:0] rev8(input logic [7:0] b);
    logic [7:0] r;
    int k;
    for (k = 0; k < 8; k++) begin
      r[7-k] = b[k];
    end
    return r;
  endfunction

  // Whitening LFSR x^7+x^4+1, cell 0 = 1, cells 1..6 = channel (MSB first).
  // Evaluated at elaboration only.
  function automatic wtab_t white_tbl(input logic [5:0] ch);
    logic [6:0] w;
    logic       o;
    wtab_t      t;
    int         p;
    int         k;
    w = 7'd1;
    for (k = 0; k < 6; k++) begin
      w[1+k] = ch[5-k];
    end
    for (p = 0; p < 64; p++) begin
      for (k = 0; k < 8; k++) begin
        o       = w[6];
        t[p][k] = o;
        w       = {w[5:0], o};
        w[4]    = w[4] ^ o;
      end
    end
    return t;
  endfunction

  // Bytewise CRC-24 update; state packed {c0, c1, c2}, returns {n0, n1, n2}
  function automatic logic [23:0] crc_step(input logic [23:0] cur,
                                           input logic [7:0]  b);
    logic [7:0] e;
    logic [7:0] n0;
    logic [7:0] n1;
    logic [7:0] n2;
    e  = rev8(b) ^ cur[7:0];
    n2 = (e >> 6) ^ (e >> 7) ^ cur[15:8];
    n1 = (e << 1) ^ (e << 2) ^ (e >> 2) ^ (e >> 4) ^ (e >> 5) ^ (e >> 7)
       ^ cur[23:16];
    n0 = e ^ (e << 1) ^ (e << 3) ^ (e << 4) ^ (e << 6);
    return {n0, n1, n2};
  endfunction

endpackage

@@ rtl/ble_crc24_whitening_tx.sv @@
// BLE advertising transmit path: CRC-24 append and data whitening.
// Depends on blecrcw_pkg (CRC step, whitening tables, register indexes).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one PDU byte per word
//   plus last_byte_i on the final PDU byte. Output channel (out_valid_o /
//   out_stall_i) carries whitened bytes in transmit order; out_last_o marks
//   the third CRC byte, too_long_o flags positions at or past TABLE_BYTES.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (0 = channel, 1 = crc_seed). Channel 37/38/39 selects a whitening table,
//   any other value sends bytes in the clear.
// Timing:
//   A byte is registered into the output stage at the edge that accepts it,
//   one byte per cycle sustained while the receiver takes them and no CRC
//   bytes are pending. A word with last_byte_i set is followed by three CRC
//   bytes on the next three output slots; the input is stalled while they
//   drain, so a packet of N bytes yields N+3 output bytes. The output register
//   is refilled in the same cycle it is taken; when the receiver stalls, the
//   held word stays put and in_stall_o rises combinationally with out_stall_i.
// Reset: output empty, byte position 0, channel 37, seed 0x555555.

module ble_crc24_whitening_tx #(
  parameter int TABLE_BYTES = 39
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  // PDU byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  pdu_byte_i,
  input  logic        last_byte_i,
  // whitened byte output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        too_long_o
);

  import blecrcw_pkg::*;

  localparam wtab_t Wt37 = white_tbl(ChAdv37);
  localparam wtab_t Wt38 = white_tbl(ChAdv38);
  localparam wtab_t Wt39 = white_tbl(ChAdv39);
  localparam logic [5:0] TableLen = 6'(TABLE_BYTES);

  // config registers
  logic [5:0]  channel_q;
  logic [23:0] crc_seed_q;

  // packet state
  logic [23:0] crc_q, crc_d;       // running CRC, {c0, c1, c2}
  logic [5:0]  byte_index_q, byte_index_d;
  logic [23:0] pend_q, pend_d;     // CRC bytes waiting, next one on top
  logic [1:0]  pend_cnt_q, pend_cnt_d;

  // output stage
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic        too_long_q, too_long_d;

  logic        load;
  logic        in_acc;
  logic        crc_emit;
  logic        emit;
  logic [7:0]  raw_byte;
  logic        emit_last;
  logic        pos_long;
  logic [7:0]  key;
  logic [23:0] crc_cur;
  logic [23:0] crc_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_q  <= ChannelReset;
      crc_seed_q <= CrcSeedReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgChannel: channel_q  <= cfg_data_i[5:0];
        CfgCrcSeed: crc_seed_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Handshake: the output slot is free if empty or being taken this cycle.
  assign load       = !out_valid_q || !out_stall_i;
  assign in_stall_o = (pend_cnt_q != 2'd0) || !load;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign crc_emit   = (pend_cnt_q != 2'd0) && load;
  assign emit       = in_acc || crc_emit;

  // Position 0 opens a packet and starts from the seed.
  assign crc_cur = (byte_index_q == 6'd0) ? crc_seed_q : crc_q;
  assign crc_new = crc_step(crc_cur, pdu_byte_i);

  assign raw_byte  = crc_emit ? pend_q[23:16] : pdu_byte_i;
  assign emit_last = crc_emit && (pend_cnt_q == 2'd1);
  assign pos_long  = byte_index_q >= TableLen;

  always_comb begin
    key = 8'd0;
    if (!pos_long) begin
      case (channel_q)
        ChAdv37: key = Wt37[byte_index_q];
        ChAdv38: key = Wt38[byte_index_q];
        ChAdv39: key = Wt39[byte_index_q];
        default: key = 8'd0;
      endcase
    end
  end

  always_comb begin
    crc_d        = crc_q;
    byte_index_d = byte_index_q;
    pend_d       = pend_q;
    pend_cnt_d   = pend_cnt_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    too_long_d   = too_long_q;

    if (in_acc) begin
      crc_d = crc_new;
      if (last_byte_i) begin
        // transmit order: rev(n2), rev(n1), rev(n0)
        pend_d     = {rev8(crc_new[7:0]), rev8(crc_new[15:8]), rev8(crc_new[23:16])};
        pend_cnt_d = 2'd3;
      end
    end else if (crc_emit) begin
      pend_d     = {pend_q[15:0], 8'd0};
      pend_cnt_d = pend_cnt_q - 2'd1;
    end

    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = raw_byte ^ key;
      out_last_d  = emit_last;
      too_long_d  = pos_long;
      if (emit_last) begin
        byte_index_d = 6'd0;
      end else if (byte_index_q != IdxMax) begin
        byte_index_d = byte_index_q + 6'd1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= 6'd0;
      pend_cnt_q   <= 2'd0;
      out_valid_q  <= 1'b0;
    end else begin
      byte_index_q <= byte_index_d;
      pend_cnt_q   <= pend_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q      <= crc_d;
    pend_q     <= pend_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    too_long_q <= too_long_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign too_long_o  = too_long_q;

  // A last PDU byte queues exactly three CRC bytes.
  a_last_queues_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> pend_cnt_q == 2'd3)
    else $error("CRC bytes not queued after last PDU byte");

  // No PDU byte is taken while CRC bytes are still pending.
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q != 2'd0 |-> !in_acc)
    else $error("input accepted while CRC bytes pending");

  // Final CRC byte closes the packet: position back to zero.
  a_end_resets_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_emit && pend_cnt_q == 2'd1 |=> byte_index_q == 6'd0 && out_last_q)
    else $error("packet end did not reset byte position");

  // While the closing byte sits in the output stage, no packet is open.
  a_last_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> byte_index_q == 6'd0 && pend_cnt_q == 2'd0)
    else $error("state not idle while closing byte is held");

endmodule

@@ bench/ble_crc24_whitening_tx_test.sv @@
// Self-checking bench for ble_crc24_whitening_tx: a directed table, then random packets
// checked against an in-bench CRC-24 / whitening predictor.
// Depends on blecrcw_pkg (register indexes, reset values, channel codes) and the RTL.

module ble_crc24_whitening_tx_test;
  timeunit 1ns;
  timeprecision 1ps;

  import blecrcw_pkg::*;

  localparam int TableBytes = 39;
  localparam int RandItems  = 140;
  localparam int HoldCycles = 80;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [23:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  pdu_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        too_long_o;

  ble_crc24_whitening_tx #(
    .TABLE_BYTES(TableBytes)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pdu_byte_i (pdu_byte_i),
    .last_byte_i(last_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .too_long_o (too_long_o)
  );

  // 2 ns period
  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of channel, seed, running CRC and byte position.
  // Every accepted PDU byte pushes one or four expected tx words.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       tl;
  } tx_word_t;

  tx_word_t    tx_expect_q[$];
  logic [5:0]  chan_m;
  logic [23:0] seed_m;
  logic [23:0] crc_m;
  logic [5:0]  pos_m;

  int err_cnt    = 0;
  int words_seen = 0;
  int bytes_sent = 0;
  int pkts_sent  = 0;
  int reg_writes = 0;
  int burst_left = 0;
  bit hold_armed = 1'b0;

  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) r[k] = b[7-k];
    return r;
  endfunction

  // Run the x^7+x^4+1 whitening LFSR up to this position; the next 8 output bits
  // form the key, LSB first. Cell 0 seeds to 1, cells 6..1 get channel bits 0..5.
  function automatic logic [7:0] whiten_key(input logic [5:0] ch, input logic [5:0] pos);
    logic [6:0] lfsr;
    logic       fb;
    logic [7:0] key;
    int         base;
    lfsr = {ch[0], ch[1], ch[2], ch[3], ch[4], ch[5], 1'b1};
    key  = '0;
    base = 8 * int'(pos);
    for (int n = 0; n < base + 8; n++) begin
      fb = lfsr[6];
      if (n >= base) key[n-base] = fb;
      lfsr = {lfsr[5:0], fb} ^ {2'b00, fb, 4'b0000};
    end
    return key;
  endfunction

  // Bytewise CRC-24 fold; state packed {c0, c1, c2}
  function automatic logic [23:0] crc_fold(input logic [23:0] st, input logic [7:0] b);
    logic [7:0] e;
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
    e  = flip8(b) ^ st[7:0];
    m2 = (e >> 6) ^ (e >> 7) ^ st[15:8];
    m1 = (e << 1) ^ (e << 2) ^ (e >> 2) ^ (e >> 4) ^ (e >> 5) ^ (e >> 7) ^ st[23:16];
    m0 = e ^ (e << 1) ^ (e << 3) ^ (e << 4) ^ (e << 6);
    return {m0, m1, m2};
  endfunction

  // Queue one tx word at the current position; past the table it goes out in
  // the clear with the too-long flag, on every channel. Position saturates.
  function automatic void emit_word(input logic [7:0] b, input logic lst);
    tx_word_t w;
    w.tl   = (pos_m >= TableBytes);
    w.data = b;
    w.last = lst;
    if (!w.tl && (chan_m == ChAdv37 || chan_m == ChAdv38 || chan_m == ChAdv39))
      w.data = b ^ whiten_key(chan_m, pos_m);
    tx_expect_q.push_back(w);
    if (pos_m != IdxMax) pos_m++;
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic lst);
    logic [23:0] nxt;
    // packet start picks up the seed, so seed writes land at the next packet
    nxt   = crc_fold((pos_m == 0) ? seed_m : crc_m, b);
    crc_m = nxt;
    emit_word(b, 1'b0);
    bytes_sent++;
    if (lst) begin
      // CRC goes out as reversed c2, c1, c0
      emit_word(flip8(nxt[7:0]), 1'b0);
      emit_word(flip8(nxt[15:8]), 1'b0);
      emit_word(flip8(nxt[23:16]), 1'b1);
      pos_m = '0;
      crc_m = seed_m;
      pkts_sent++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output monitor: every accepted word is checked against the oldest
  // expectation. Samples pre-edge values, all drives are nonblocking.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : tx_monitor
    tx_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (tx_expect_q.size() == 0) begin
        $error("unexpected tx word: out_byte %02h out_last %0b too_long %0b",
               out_byte_o, out_last_o, too_long_o);
        err_cnt++;
      end else begin
        w = tx_expect_q.pop_front();
        if (out_byte_o !== w.data) begin
          $error("out_byte: expected %02h, got %02h", w.data, out_byte_o);
          err_cnt++;
        end
        if (out_last_o !== w.last) begin
          $error("out_last: expected %0b, got %0b", w.last, out_last_o);
          err_cnt++;
        end
        if (too_long_o !== w.tl) begin
          $error("too_long: expected %0b, got %0b", w.tl, too_long_o);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern in segments of random length (free running,
  // random, periodic, bursty), plus one long hold-off when armed so the
  // output register fills and the input side backs up.
  // ---------------------------------------------------------------------------
  initial begin : rx_stall_gen
    int seg_len;
    int seg_kind;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      seg_len  = $urandom_range(5, 40);
      seg_kind = $urandom_range(0, 3);
      for (int i = 0; i < seg_len; i++) begin
        case (seg_kind)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 99) < 40);
          2: out_stall_i <= (i % 3 == 0);
          default: out_stall_i <= (i % 6 < 3);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender helpers. All called on a clock edge.
  // ---------------------------------------------------------------------------

  // Offer one word and hold it until the edge that takes it.
  task automatic push_word(input logic [7:0] b, input logic lst);
    in_valid_i  <= 1'b1;
    pdu_byte_i  <= b;
    last_byte_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, lst);
  endtask

  // Bursty sender: random burst lengths with random gaps between them.
  task automatic offer(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    push_word(b, lst);
  endtask

  // Drop valid and wait until every expected word is back, then let the
  // output register settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register write, only from idle.
  task automatic set_reg(input logic idx, input logic [23:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgChannel) chan_m = val[5:0];
    else seed_m = val;
    reg_writes++;
  endtask

  function automatic logic [5:0] pick_channel();
    case ($urandom_range(0, 5))
      0: return ChAdv37;
      1: return ChAdv38;
      2: return ChAdv39;
      3: return 6'd0;
      default: return 6'($urandom_range(0, 39));
    endcase
  endfunction

  function automatic logic [23:0] pick_seed();
    case ($urandom_range(0, 3))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return CrcSeedReset;
      default: return 24'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Byte rows may repeat to build long packets. A typed row
  // replaces the predicted PDU word with a value readable by eye: unwhitened
  // channels, and positions past the table.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {RowByte, RowChan, RowSeed} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [23:0] val;
    logic        last;
    int          reps;
    logic        typed;
    logic [7:0]  exp_byte;
    logic        exp_tl;
  } step_row_t;

  localparam int NumRows = 21;

  step_row_t plan [NumRows] = '{
    // reset settings: channel 37, seed 0x555555
    '{RowByte, 24'h00,     1'b1, 1,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'hFF,     1'b0, 1,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'hA5,     1'b1, 1,  1'b0, 8'h00, 1'b0},
    // no whitening: PDU bytes pass as they are
    '{RowChan, 24'd0,      1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h5A,     1'b0, 1,  1'b1, 8'h5A, 1'b0},
    '{RowByte, 24'hFF,     1'b1, 1,  1'b1, 8'hFF, 1'b0},
    '{RowSeed, 24'h000000, 1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h00,     1'b1, 1,  1'b1, 8'h00, 1'b0},
    // channel changes mid-packet, seed written mid-packet
    '{RowSeed, 24'hFFFFFF, 1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowChan, 24'd38,     1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h12,     1'b0, 1,  1'b0, 8'h00, 1'b0},
    '{RowChan, 24'd39,     1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h34,     1'b0, 1,  1'b0, 8'h00, 1'b0},
    '{RowSeed, 24'h123456, 1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h56,     1'b1, 1,  1'b0, 8'h00, 1'b0},
    // overlong packet on a whitened channel, position saturates at 63
    '{RowChan, 24'd37,     1'b0, 0,  1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h3C,     1'b0, 39, 1'b0, 8'h00, 1'b0},
    '{RowByte, 24'hC3,     1'b0, 1,  1'b1, 8'hC3, 1'b1},
    '{RowByte, 24'h77,     1'b0, 30, 1'b0, 8'h00, 1'b0},
    '{RowByte, 24'h81,     1'b1, 1,  1'b1, 8'h81, 1'b1},
    '{RowSeed, 24'h555555, 1'b0, 0,  1'b0, 8'h00, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stim
    int  slot;
    int  n_rand;
    int  len;
    logic lst;

    // all inputs known from time 0
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgChannel;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    pdu_byte_i  = '0;
    last_byte_i = 1'b0;
    out_stall_i = 1'b0;

    chan_m = ChannelReset;
    seed_m = CrcSeedReset;
    crc_m  = CrcSeedReset;
    pos_m  = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    for (int r = 0; r < NumRows; r++) begin
      case (plan[r].kind)
        RowChan: set_reg(CfgChannel, plan[r].val);
        RowSeed: set_reg(CfgCrcSeed, plan[r].val);
        default: begin
          for (int k = 0; k < plan[r].reps; k++) begin
            lst = plan[r].last && (k == plan[r].reps - 1);
            offer(plan[r].val[7:0], lst);
            if (plan[r].typed) begin
              slot = tx_expect_q.size() - (lst ? 4 : 1);
              tx_expect_q[slot].data = plan[r].exp_byte;
              tx_expect_q[slot].tl   = plan[r].exp_tl;
            end
          end
        end
      endcase
    end

    // random packets: mostly short, now and then past the table; the
    // receiver's long hold-off kicks in while these stream
    wait_drained();
    hold_armed = 1'b1;
    n_rand = 0;
    while (n_rand < RandItems) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) set_reg(CfgChannel, 24'(pick_channel()));
        if ($urandom_range(0, 1) == 0) set_reg(CfgCrcSeed, pick_seed());
      end
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(36, 70) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) begin
        // occasional channel switch between bytes of a packet
        if (i != 0 && $urandom_range(0, 39) == 0) set_reg(CfgChannel, 24'(pick_channel()));
        offer(8'($urandom_range(0, 255)), i == len - 1);
        n_rand++;
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);

    $display("Covered %0d PDU bytes in %0d packets with %0d register writes;",
             bytes_sent, pkts_sent, reg_writes);
    $display("%0d output words checked, %0d mismatches.", words_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin : watchdog
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ files.f @@
rtl/blecrcw_pkg.sv
rtl/ble_crc24_whitening_tx.sv
bench/ble_crc24_whitening_tx_test.sv
